// File: rtl/trace_ring_with_drop_count_core_macros.svh
// Assertion macros shared by the trace ring RTL.
// Included by the controller and datapath modules; depends on nothing.
`ifndef TRACE_RING_WITH_DROP_COUNT_CORE_MACROS_SVH
`define TRACE_RING_WITH_DROP_COUNT_CORE_MACROS_SVH

// Same-cycle implication, disabled in reset
`define TRDC_ASSERT_NOW(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled in reset
`define TRDC_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/trdc_pkg.sv
// Shared constants, field layout and controller/datapath command types
// for the trace ring. No dependencies.
package trdc_pkg;

  // Sizes
  localparam int DEPTH      = 4096;
  localparam int AW         = $clog2(DEPTH);
  localparam int CAPW       = AW + 1;
  localparam int MAX_BURST  = 64;
  localparam int LIMW       = 7;
  localparam int SW         = 64;
  localparam int CW         = 48;

  localparam logic [CAPW-1:0] CAP_DEFAULT = CAPW'(2400);
  localparam logic [CAPW-1:0] CAP_MAX     = CAPW'(DEPTH);
  localparam logic [LIMW-1:0] BURST_MAX   = LIMW'(MAX_BURST);

  // Item kinds (s_axis_tuser)
  localparam logic [1:0] KIND_PUSH  = 2'd0;
  localparam logic [1:0] KIND_DRAIN = 2'd1;
  localparam logic [1:0] KIND_SNAP  = 2'd2;

  // Input tdata: sample, from_index, max_count
  localparam int IN_SMP_LO  = 0;
  localparam int IN_FROM_LO = IN_SMP_LO + SW;
  localparam int IN_LIM_LO  = IN_FROM_LO + CW;
  localparam int IN_BITS    = IN_LIM_LO + LIMW;
  localparam int IN_TDATA_W = ((IN_BITS + 7) / 8) * 8;

  // Output tdata: sample_out, count, next_index, dropped, total_pushed
  localparam int OUT_SMP_LO  = 0;
  localparam int OUT_CNT_LO  = OUT_SMP_LO + SW;
  localparam int OUT_NEXT_LO = OUT_CNT_LO + LIMW;
  localparam int OUT_DROP_LO = OUT_NEXT_LO + CW;
  localparam int OUT_TOT_LO  = OUT_DROP_LO + CW;
  localparam int OUT_BITS    = OUT_TOT_LO + CW;
  localparam int OUT_TDATA_W = ((OUT_BITS + 7) / 8) * 8;

  // Controller to datapath
  typedef struct packed {
    logic cap_wr;       // capacity write, ring emptied
    logic push;         // store sample, count it, load acknowledgement
    logic drain_zero;   // drain with zero limit: echo cursor
    logic take;         // latch drain/snapshot request
    logic clamp;        // oldest kept entry, or snapshot size
    logic adjust;       // move stale cursor, count lost entries
    logic size;         // available entries and burst size
    logic locate;       // start slot and next cursor
    logic rd;           // read one slot, advance slot pointer
    logic emit_sample;  // load one sample result
    logic emit_none;    // load empty result
  } trdc_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic       out_free;
    logic [1:0] in_kind;
    logic       in_lim_zero;
    logic       snap;
    logic       want_zero;
    logic       last_one;
  } trdc_stat_t;

endpackage

// File: rtl/trdc_ctrl.sv
// Sequencer for the trace ring: walks each drain or snapshot through its
// setup steps and the sample stream. Depends on trdc_pkg and the macro header.
`include "trace_ring_with_drop_count_core_macros.svh"

module trdc_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               s_axis_tvalid,
  output logic               s_axis_tready,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  trdc_pkg::trdc_stat_t stat,
  output trdc_pkg::trdc_cmd_t  cmd
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_CLAMP,
    S_ADJUST,
    S_SIZE,
    S_LOCATE,
    S_EMPTY,
    S_PRIME,
    S_EMIT
  } state_t;

  state_t state;
  state_t state_next;
  logic   accept;

  // Handshakes: config wins over a data item in the same cycle
  assign cfg_ready     = (state == S_IDLE);
  assign s_axis_tready = (state == S_IDLE) && stat.out_free && !cfg_valid;
  assign accept        = s_axis_tvalid && s_axis_tready;

  // Command decode and next state
  always_comb begin
    cmd        = '0;
    state_next = state;
    unique case (state)
      S_IDLE: begin
        cmd.cap_wr = cfg_valid;
        if (accept) begin
          unique case (stat.in_kind)
            trdc_pkg::KIND_PUSH: cmd.push = 1'b1;
            trdc_pkg::KIND_DRAIN: begin
              if (stat.in_lim_zero) begin
                cmd.drain_zero = 1'b1;
              end else begin
                cmd.take   = 1'b1;
                state_next = S_CLAMP;
              end
            end
            trdc_pkg::KIND_SNAP: begin
              cmd.take   = 1'b1;
              state_next = S_CLAMP;
            end
            default: ;  // unused kind: dropped silently
          endcase
        end
      end
      S_CLAMP: begin
        cmd.clamp  = 1'b1;
        state_next = stat.snap ? S_LOCATE : S_ADJUST;
      end
      S_ADJUST: begin
        cmd.adjust = 1'b1;
        state_next = S_SIZE;
      end
      S_SIZE: begin
        cmd.size   = 1'b1;
        state_next = S_LOCATE;
      end
      S_LOCATE: begin
        cmd.locate = 1'b1;
        state_next = stat.want_zero ? S_EMPTY : S_PRIME;
      end
      S_EMPTY: begin
        if (stat.out_free) begin
          cmd.emit_none = 1'b1;
          state_next    = S_IDLE;
        end
      end
      S_PRIME: begin
        cmd.rd     = 1'b1;
        state_next = S_EMIT;
      end
      S_EMIT: begin
        if (stat.out_free) begin
          cmd.emit_sample = 1'b1;
          if (stat.last_one) begin
            state_next = S_IDLE;
          end else begin
            cmd.rd = 1'b1;
          end
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Checks
  `TRDC_ASSERT_NOW(ctrl_single_entry, clk, rst, 1'b1,
    ($onehot0({cmd.cap_wr, cmd.push, cmd.drain_zero, cmd.take})),
    "ctrl: more than one entry command in a cycle")
  `TRDC_ASSERT_NEXT(ctrl_take_starts, clk, rst, cmd.take,
    (state == S_CLAMP), "ctrl: request taken but setup not started")
  `TRDC_ASSERT_NOW(ctrl_read_feeds_emit, clk, rst, (state == S_EMIT && cmd.rd),
    (stat.out_free && !stat.last_one), "ctrl: read issued past end of burst")

endmodule

// File: rtl/trdc_datapath.sv
// Datapath for the trace ring: sample RAM, push total, cursor arithmetic
// and the output register. Depends on trdc_pkg and the macro header.
`include "trace_ring_with_drop_count_core_macros.svh"

module trdc_datapath (
  input  logic                                clk,
  input  logic                                rst,
  input  trdc_pkg::trdc_cmd_t                 cmd,
  output trdc_pkg::trdc_stat_t                stat,
  input  logic [trdc_pkg::CAPW-1:0]           cfg_data,
  input  logic [trdc_pkg::IN_TDATA_W-1:0]     s_axis_tdata,
  input  logic [1:0]                          s_axis_tuser,
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  output logic [trdc_pkg::OUT_TDATA_W-1:0]    m_axis_tdata,
  output logic                                m_axis_tuser,
  output logic                                m_axis_tlast
);

  localparam int AW   = trdc_pkg::AW;
  localparam int CAPW = trdc_pkg::CAPW;
  localparam int CW   = trdc_pkg::CW;
  localparam int SW   = trdc_pkg::SW;
  localparam int LIMW = trdc_pkg::LIMW;

  // Sample RAM
  logic [SW-1:0] mem [trdc_pkg::DEPTH];
  logic [SW-1:0] rdata;

  // Ring state
  logic [CAPW-1:0] cap;
  logic [CW-1:0]   total;
  logic [AW-1:0]   wr_slot;

  // Request registers
  logic            snap_q;
  logic [CW-1:0]   from_q;
  logic [LIMW-1:0] lim_q;
  logic [CW-1:0]   first_kept;
  logic [CW-1:0]   drop_q;
  logic [LIMW-1:0] want_q;
  logic [CAPW-1:0] back_q;
  logic [CW-1:0]   next_q;
  logic [AW-1:0]   slot_q;
  logic [LIMW-1:0] remain;

  // Output register
  logic            out_valid;
  logic [SW-1:0]   o_sample;
  logic            o_has;
  logic            o_last;
  logic [LIMW-1:0] o_count;
  logic [CW-1:0]   o_next;
  logic [CW-1:0]   o_drop;
  logic [CW-1:0]   o_total;

  // Input fields
  logic [SW-1:0]   in_sample;
  logic [CW-1:0]   in_from;
  logic [LIMW-1:0] in_lim;
  logic [LIMW-1:0] in_lim_sat;
  logic [CAPW-1:0] cap_wr_val;

  assign in_sample  = s_axis_tdata[trdc_pkg::IN_SMP_LO +: SW];
  assign in_from    = s_axis_tdata[trdc_pkg::IN_FROM_LO +: CW];
  assign in_lim     = s_axis_tdata[trdc_pkg::IN_LIM_LO +: LIMW];
  assign in_lim_sat = (in_lim > trdc_pkg::BURST_MAX) ? trdc_pkg::BURST_MAX : in_lim;

  // Zero selects the default; above the RAM depth clamps to it
  assign cap_wr_val = (cfg_data == '0) ? trdc_pkg::CAP_DEFAULT :
                      (cfg_data > trdc_pkg::CAP_MAX) ? trdc_pkg::CAP_MAX : cfg_data;

  // Setup arithmetic
  logic [CW-1:0]   cap_w;
  logic [CW-1:0]   total_p1;
  logic [CAPW-1:0] wr_p1;
  logic [CAPW-1:0] rd_p1;
  logic [CAPW-1:0] snap_avail;
  logic [LIMW-1:0] snap_want;
  logic [CW-1:0]   avail;
  logic [LIMW-1:0] drain_want;
  logic [CAPW-1:0] ws_ext;
  logic [CAPW-1:0] start_slot;

  assign cap_w      = {{(CW-CAPW){1'b0}}, cap};
  assign total_p1   = total + CW'(1);
  assign wr_p1      = {1'b0, wr_slot} + CAPW'(1);
  assign rd_p1      = {1'b0, slot_q} + CAPW'(1);
  assign snap_avail = (total < cap_w) ? total[CAPW-1:0] : cap;
  assign snap_want  = ({{(CAPW-LIMW){1'b0}}, lim_q} < snap_avail) ? lim_q
                                                                  : snap_avail[LIMW-1:0];
  assign avail      = (total > from_q) ? (total - from_q) : '0;
  assign drain_want = (avail < {{(CW-LIMW){1'b0}}, lim_q}) ? avail[LIMW-1:0] : lim_q;
  assign ws_ext     = {1'b0, wr_slot};
  assign start_slot = (ws_ext >= back_q) ? (ws_ext - back_q) : (ws_ext + cap - back_q);

  // RAM write on push, registered read
  always_ff @(posedge clk) begin
    if (cmd.push) begin
      mem[wr_slot] <= in_sample;
    end
    if (cmd.rd) begin
      rdata <= mem[slot_q];
    end
  end

  // Ring state: capacity, push total, write slot
  // (the write slot restarts with the total when the total wraps)
  always_ff @(posedge clk) begin
    if (rst) begin
      cap     <= trdc_pkg::CAP_DEFAULT;
      total   <= '0;
      wr_slot <= '0;
    end else if (cmd.cap_wr) begin
      cap     <= cap_wr_val;
      total   <= '0;
      wr_slot <= '0;
    end else if (cmd.push) begin
      total   <= total_p1;
      wr_slot <= ((wr_p1 == cap) || (total_p1 == '0)) ? '0 : wr_p1[AW-1:0];
    end
  end

  // Drain / snapshot setup and stream bookkeeping
  always_ff @(posedge clk) begin
    if (cmd.take) begin
      snap_q <= (s_axis_tuser == trdc_pkg::KIND_SNAP);
      from_q <= in_from;
      lim_q  <= in_lim_sat;
    end
    if (cmd.clamp) begin
      if (snap_q) begin
        want_q <= snap_want;
        back_q <= {{(CAPW-LIMW){1'b0}}, snap_want};
        drop_q <= '0;
      end else begin
        first_kept <= (total > cap_w) ? (total - cap_w) : '0;
      end
    end
    if (cmd.adjust) begin
      if (from_q < first_kept) begin
        drop_q <= first_kept - from_q;
        from_q <= first_kept;
      end else begin
        drop_q <= '0;
      end
    end
    if (cmd.size) begin
      want_q <= drain_want;
      back_q <= avail[CAPW-1:0];
    end
    if (cmd.locate) begin
      slot_q <= start_slot[AW-1:0];
      next_q <= snap_q ? total : (from_q + {{(CW-LIMW){1'b0}}, want_q});
      remain <= want_q;
    end else if (cmd.rd) begin
      slot_q <= (rd_p1 == cap) ? '0 : rd_p1[AW-1:0];
    end
    if (cmd.emit_sample) begin
      remain <= remain - LIMW'(1);
    end
  end

  // Output register
  logic load;
  assign load = cmd.push || cmd.drain_zero || cmd.emit_sample || cmd.emit_none;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.push) begin
      o_sample <= '0;
      o_has    <= 1'b0;
      o_last   <= 1'b1;
      o_count  <= '0;
      o_next   <= total_p1;
      o_drop   <= '0;
      o_total  <= total_p1;
    end else if (cmd.drain_zero) begin
      o_sample <= '0;
      o_has    <= 1'b0;
      o_last   <= 1'b1;
      o_count  <= '0;
      o_next   <= in_from;
      o_drop   <= '0;
      o_total  <= total;
    end else if (cmd.emit_sample) begin
      o_sample <= rdata;
      o_has    <= 1'b1;
      o_last   <= (remain == LIMW'(1));
      o_count  <= want_q;
      o_next   <= next_q;
      o_drop   <= drop_q;
      o_total  <= total;
    end else if (cmd.emit_none) begin
      o_sample <= '0;
      o_has    <= 1'b0;
      o_last   <= 1'b1;
      o_count  <= '0;
      o_next   <= next_q;
      o_drop   <= drop_q;
      o_total  <= total;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tuser  = o_has;
  assign m_axis_tlast  = o_last;
  assign m_axis_tdata  = {{(trdc_pkg::OUT_TDATA_W - trdc_pkg::OUT_BITS){1'b0}},
                          o_total, o_drop, o_next, o_count, o_sample};

  // Status
  assign stat.out_free    = !out_valid || m_axis_tready;
  assign stat.in_kind     = s_axis_tuser;
  assign stat.in_lim_zero = (in_lim == '0);
  assign stat.snap        = snap_q;
  assign stat.want_zero   = (want_q == '0);
  assign stat.last_one    = (remain == LIMW'(1));

  // Checks
  `TRDC_ASSERT_NOW(dp_wr_slot_range, clk, rst, 1'b1, ({1'b0, wr_slot} < cap),
    "dp: write slot outside ring")
  `TRDC_ASSERT_NOW(dp_load_when_free, clk, rst, load, (!out_valid || m_axis_tready),
    "dp: output register overwritten before transaction")
  `TRDC_ASSERT_NEXT(dp_push_counts, clk, rst, (cmd.push && !cmd.cap_wr),
    (total == $past(total) + CW'(1)), "dp: push not counted")

endmodule

// File: rtl/trace_ring_with_drop_count_core.sv
// Top level of the trace ring: ties the sequencer to the datapath.
// Depends on trdc_pkg, trdc_ctrl and trdc_datapath.

// Overwriting trace ring of 64-bit samples over a 4096 x 64 single-port-read
// RAM, with a 48-bit running push total. A push (tuser 0) or a drain with a zero
// limit is handled straight from idle, and such requests can arrive back to back
// while the receiver takes each result transaction. A drain (tuser 1) or snapshot
// (tuser 2) then passes through the setup steps clamp, adjust, size and locate
// (a snapshot skips adjust and size), 48-bit compare/subtract steps, each its own
// register stage, and a RAM read (prime), and then streams one sample per cycle
// while the receiver is ready, limited by the RAM read port; a count of 0 gives
// one empty result. Requests are handled one at a time.
// A capacity write empties the ring logically; there is no clearing pass.
// tuser value 3 is accepted and ignored.
module trace_ring_with_drop_count_core (
  input  logic                              clk,
  input  logic                              rst,
  // Requests
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  // [63:0] sample, [111:64] cursor, [118:112] max_count, [119] zero
  input  logic [trdc_pkg::IN_TDATA_W-1:0]   s_axis_tdata,
  // [1:0] kind
  input  logic [1:0]                        s_axis_tuser,
  // Results
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  // [63:0] sample_out, [70:64] count, [118:71] next_index,
  // [166:119] dropped, [214:167] total_pushed, [215] zero
  output logic [trdc_pkg::OUT_TDATA_W-1:0]  m_axis_tdata,
  // [0] has_sample
  output logic                              m_axis_tuser,
  output logic                              m_axis_tlast,
  // Capacity register write
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [trdc_pkg::CAPW-1:0]         cfg_data
);

  trdc_pkg::trdc_cmd_t  cmd;
  trdc_pkg::trdc_stat_t stat;

  trdc_ctrl u_ctrl (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .stat          (stat),
    .cmd           (cmd)
  );

  trdc_datapath u_dp (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .stat          (stat),
    .cfg_data      (cfg_data),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

endmodule

// File: verif/tb.sv
// Self-checking testbench for trace_ring_with_drop_count_core: pushes, drains and snapshots
// are driven over the request stream and every result is checked against a behavioral ring.
// Depends on trdc_pkg and the core RTL.
module tb;

  localparam int HALF_PERIOD   = 10;
  localparam int RESET_CYCLES  = 8;
  localparam int SETTLE_CYCLES = 16;    // drain setup plus one empty result, with margin
  localparam int STALL_LIMIT   = 5000;  // cycles with no transaction anywhere
  localparam int HOLD_CYCLES   = 200;   // long receiver back-pressure stretch
  localparam int PRINT_LIMIT   = 30;

  localparam logic [1:0] KIND_UNUSED = 2'd3;

  // One expected result transaction
  typedef struct {
    logic [trdc_pkg::SW-1:0]   smp;
    logic                      has;
    logic                      is_last;
    logic [trdc_pkg::LIMW-1:0] cnt;
    logic [trdc_pkg::CW-1:0]   next;
    logic [trdc_pkg::CW-1:0]   lost;
    logic [trdc_pkg::CW-1:0]   total;
  } ring_result_t;

  logic                               clk = 1'b0;
  logic                               rst = 1'b1;
  logic                               s_axis_tvalid = 1'b0;
  logic                               s_axis_tready;
  logic [trdc_pkg::IN_TDATA_W-1:0]    s_axis_tdata = '0;
  logic [1:0]                         s_axis_tuser = '0;
  logic                               m_axis_tvalid;
  logic                               m_axis_tready = 1'b0;
  logic [trdc_pkg::OUT_TDATA_W-1:0]   m_axis_tdata;
  logic                               m_axis_tuser;
  logic                               m_axis_tlast;
  logic                               cfg_valid = 1'b0;
  logic                               cfg_ready;
  logic [trdc_pkg::CAPW-1:0]          cfg_data = '0;

  // Behavioral copy of the ring
  logic [trdc_pkg::SW-1:0]   shadow_mem [trdc_pkg::DEPTH];
  logic [trdc_pkg::CW-1:0]   shadow_total = '0;
  logic [trdc_pkg::CAPW-1:0] shadow_cap = trdc_pkg::CAP_DEFAULT;

  ring_result_t pending_results [$];

  int src_idle_pct  = 0;
  int sink_idle_pct = 0;
  int sink_hold     = 0;
  int stall_cycles  = 0;
  int err_count     = 0;
  int n_push = 0, n_drain = 0, n_snap = 0, n_ignored = 0, n_cap_writes = 0;
  int n_checked = 0, n_samples = 0;

  trace_ring_with_drop_count_core u_top (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_data      (cfg_data)
  );

  always #HALF_PERIOD clk = ~clk;

  // Slots in use: zero picks the default, oversize clamps to the RAM depth
  function automatic logic [trdc_pkg::CW-1:0] ring_slots();
    logic [trdc_pkg::CW-1:0] c;
    c = (shadow_cap == '0) ? trdc_pkg::CW'(trdc_pkg::CAP_DEFAULT) : trdc_pkg::CW'(shadow_cap);
    if (c > trdc_pkg::CW'(trdc_pkg::DEPTH)) c = trdc_pkg::CW'(trdc_pkg::DEPTH);
    return c;
  endfunction

  task automatic queue_result(input logic [trdc_pkg::SW-1:0] smp, input logic has,
                              input logic is_last, input logic [trdc_pkg::LIMW-1:0] cnt,
                              input logic [trdc_pkg::CW-1:0] next,
                              input logic [trdc_pkg::CW-1:0] lost);
    ring_result_t r;
    r.smp = smp; r.has = has; r.is_last = is_last; r.cnt = cnt;
    r.next = next; r.lost = lost; r.total = shadow_total;
    pending_results.insert(pending_results.size(), r);
  endtask

  // Ring behavior for one accepted request
  task automatic ring_predict(input logic [1:0] kind, input logic [trdc_pkg::SW-1:0] smp,
                              input logic [trdc_pkg::CW-1:0] from,
                              input logic [trdc_pkg::LIMW-1:0] lim);
    logic [trdc_pkg::CW-1:0] cap, oldest, cursor, lost, avail, n, start;
    logic [trdc_pkg::LIMW-1:0] burst;
    cap = ring_slots();
    burst = (lim > trdc_pkg::BURST_MAX) ? trdc_pkg::BURST_MAX : lim;
    case (kind)
      trdc_pkg::KIND_PUSH: begin
        n_push++;
        shadow_mem[trdc_pkg::AW'(shadow_total % cap)] = smp;
        shadow_total = shadow_total + trdc_pkg::CW'(1);
        queue_result('0, 1'b0, 1'b1, '0, shadow_total, '0);
      end
      trdc_pkg::KIND_DRAIN: begin
        n_drain++;
        if (burst == '0) begin
          // zero limit echoes the cursor, no clamping
          queue_result('0, 1'b0, 1'b1, '0, from, '0);
        end else begin
          oldest = (shadow_total > cap) ? shadow_total - cap : '0;
          cursor = from;
          lost = '0;
          if (cursor < oldest) begin
            lost = oldest - cursor;
            cursor = oldest;
          end
          avail = (shadow_total > cursor) ? shadow_total - cursor : '0;
          n = (avail < trdc_pkg::CW'(burst)) ? avail : trdc_pkg::CW'(burst);
          if (n == '0) begin
            queue_result('0, 1'b0, 1'b1, '0, cursor, lost);
          end else begin
            for (logic [trdc_pkg::CW-1:0] k = '0; k < n; k++)
              queue_result(shadow_mem[trdc_pkg::AW'((cursor + k) % cap)], 1'b1,
                           k == n - trdc_pkg::CW'(1), trdc_pkg::LIMW'(n), cursor + n, lost);
          end
        end
      end
      trdc_pkg::KIND_SNAP: begin
        n_snap++;
        n = (shadow_total < cap) ? shadow_total : cap;
        if (trdc_pkg::CW'(burst) < n) n = trdc_pkg::CW'(burst);
        if (n == '0) begin
          queue_result('0, 1'b0, 1'b1, '0, shadow_total, '0);
        end else begin
          start = shadow_total - n;
          for (logic [trdc_pkg::CW-1:0] k = '0; k < n; k++)
            queue_result(shadow_mem[trdc_pkg::AW'((start + k) % cap)], 1'b1,
                         k == n - trdc_pkg::CW'(1), trdc_pkg::LIMW'(n), shadow_total, '0);
        end
      end
      default: n_ignored++;
    endcase
  endtask

  // Offer one request, with random gaps ahead of it
  task automatic send_item(input logic [1:0] kind, input logic [trdc_pkg::SW-1:0] smp,
                           input logic [trdc_pkg::CW-1:0] from,
                           input logic [trdc_pkg::LIMW-1:0] lim);
    @(negedge clk);
    while ($urandom_range(99) < src_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= kind;
    s_axis_tdata  <= {1'b0, lim, from, smp};  // pad, max_count, cursor, sample
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    ring_predict(kind, smp, from, lim);
  endtask

  // Stop offering and let every outstanding result come back
  task automatic wait_idle();
    @(negedge clk);
    s_axis_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_capacity(input logic [trdc_pkg::CAPW-1:0] value);
    wait_idle();
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    shadow_cap = value;
    shadow_total = '0;
    n_cap_writes++;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  function automatic logic [trdc_pkg::SW-1:0] rand64();
    return {$urandom, $urandom};
  endfunction

  // Mostly pushes and drains near the retained window, some noise
  task automatic send_random_item();
    int unsigned pick;
    logic [trdc_pkg::CW-1:0] cap, base, cursor;
    logic [trdc_pkg::LIMW-1:0] lim;
    pick = $urandom_range(99);
    cap = ring_slots();
    base = (shadow_total > cap) ? shadow_total - cap : '0;
    lim = ($urandom_range(9) == 0) ? trdc_pkg::LIMW'($urandom_range(64, 127))
                                   : trdc_pkg::LIMW'($urandom_range(0, 12));
    if (pick < 55) begin
      send_item(trdc_pkg::KIND_PUSH, rand64(), trdc_pkg::CW'(rand64()),
                trdc_pkg::LIMW'($urandom));
    end else if (pick < 80) begin
      case ($urandom_range(9))
        0, 1:    cursor = base - trdc_pkg::CW'($urandom_range(0, 5));
        2:       cursor = trdc_pkg::CW'(rand64());
        3:       cursor = shadow_total + trdc_pkg::CW'($urandom_range(0, 3));
        default: cursor = base + trdc_pkg::CW'($urandom_range(0, 32'(cap) + 1));
      endcase
      send_item(trdc_pkg::KIND_DRAIN, rand64(), cursor, lim);
    end else if (pick < 97) begin
      send_item(trdc_pkg::KIND_SNAP, rand64(), trdc_pkg::CW'(rand64()), lim);
    end else begin
      send_item(KIND_UNUSED, rand64(), trdc_pkg::CW'(rand64()), trdc_pkg::LIMW'($urandom));
    end
  endtask

  function automatic logic [trdc_pkg::CAPW-1:0] pick_capacity();
    case ($urandom_range(9))
      0:       return '0;
      1:       return '1;
      2:       return trdc_pkg::CAP_MAX;
      3:       return trdc_pkg::CAPW'(1);
      default: return trdc_pkg::CAPW'($urandom_range(2, 24));
    endcase
  endfunction

  // Empty ring at the reset capacity, then a few samples
  task automatic test_default_capacity();
    send_item(trdc_pkg::KIND_SNAP,  '0, '0, 7'd5);
    send_item(trdc_pkg::KIND_DRAIN, '0, '1, 7'd0);
    send_item(trdc_pkg::KIND_DRAIN, '0, '0, 7'd3);
    send_item(KIND_UNUSED, '1, '1, '1);
    send_item(trdc_pkg::KIND_PUSH, '0, '0, '0);
    send_item(trdc_pkg::KIND_PUSH, '1, '1, '1);
    send_item(trdc_pkg::KIND_PUSH, rand64(), '0, '0);
    send_item(trdc_pkg::KIND_DRAIN, '0, '0, 7'd127);
    send_item(trdc_pkg::KIND_SNAP,  '0, '0, 7'd2);
    send_item(trdc_pkg::KIND_DRAIN, '0, '1, 7'd64);
  endtask

  // Small ring overwritten: stale cursor clamps and counts the loss
  task automatic test_overwrite_drop();
    write_capacity(trdc_pkg::CAPW'(3));
    repeat (5) send_item(trdc_pkg::KIND_PUSH, rand64(), '0, '0);
    send_item(trdc_pkg::KIND_DRAIN, '0, 48'd0, 7'd2);
    send_item(trdc_pkg::KIND_DRAIN, '0, 48'd1, 7'd0);
    send_item(trdc_pkg::KIND_SNAP,  '0, '0, 7'd127);
    send_item(trdc_pkg::KIND_DRAIN, '0, 48'd4, 7'd64);
  endtask

  // Zero, oversize and single-slot capacity settings
  task automatic test_capacity_extremes();
    write_capacity('0);
    send_item(trdc_pkg::KIND_PUSH, rand64(), '0, '0);
    send_item(trdc_pkg::KIND_SNAP, '0, '0, 7'd64);
    write_capacity('1);
    send_item(trdc_pkg::KIND_PUSH, rand64(), '0, '0);
    send_item(trdc_pkg::KIND_DRAIN, '0, '0, 7'd1);
    write_capacity(trdc_pkg::CAPW'(1));
    repeat (2) send_item(trdc_pkg::KIND_PUSH, rand64(), '0, '0);
    send_item(trdc_pkg::KIND_DRAIN, '0, '0, 7'd64);
  endtask

  // Receiver stalls for a long stretch while requests keep coming
  task automatic test_output_backpressure();
    write_capacity(trdc_pkg::CAPW'(16));
    repeat (16) send_item(trdc_pkg::KIND_PUSH, rand64(), '0, '0);
    sink_hold = HOLD_CYCLES;
    repeat (6) begin
      send_item(trdc_pkg::KIND_SNAP, '0, '0, 7'd64);
      send_item(trdc_pkg::KIND_PUSH, rand64(), '0, '0);
      send_item(trdc_pkg::KIND_DRAIN, '0, '0, 7'd64);
    end
    wait_idle();
  endtask

  task automatic test_random_traffic(input int src_pct, input int sink_pct, input int n_items);
    src_idle_pct  = src_pct;
    sink_idle_pct = sink_pct;
    repeat (3) begin
      write_capacity(pick_capacity());
      repeat (n_items / 3) send_random_item();
    end
  endtask

  // Receiver ready, with random stalls and the long hold-off
  always @(negedge clk) begin
    if (sink_hold > 0) begin
      m_axis_tready <= 1'b0;
      sink_hold <= sink_hold - 1;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= sink_idle_pct);
    end
  end

  task automatic flag_mismatch(input string field, input logic [trdc_pkg::SW-1:0] exp_v,
                               input logic [trdc_pkg::SW-1:0] act_v);
    err_count++;
    if (err_count <= PRINT_LIMIT)
      $display("%0t: %s mismatch, expected %0h, got %0h", $time, field, exp_v, act_v);
  endtask

  // Compare each result transaction with the oldest expectation
  always @(posedge clk) begin : result_check
    ring_result_t exp_r;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      n_checked++;
      if (m_axis_tuser) n_samples++;
      if (pending_results.size() == 0) begin
        err_count++;
        if (err_count <= PRINT_LIMIT)
          $display("%0t: unexpected result, expected none, got tdata %0h", $time,
                   m_axis_tdata);
      end else begin
        exp_r = pending_results.pop_front();
        if (m_axis_tdata[trdc_pkg::OUT_SMP_LO +: trdc_pkg::SW] !== exp_r.smp)
          flag_mismatch("sample_out", exp_r.smp,
                        m_axis_tdata[trdc_pkg::OUT_SMP_LO +: trdc_pkg::SW]);
        if (m_axis_tuser !== exp_r.has)
          flag_mismatch("has_sample", trdc_pkg::SW'(exp_r.has), trdc_pkg::SW'(m_axis_tuser));
        if (m_axis_tlast !== exp_r.is_last)
          flag_mismatch("last", trdc_pkg::SW'(exp_r.is_last), trdc_pkg::SW'(m_axis_tlast));
        if (m_axis_tdata[trdc_pkg::OUT_CNT_LO +: trdc_pkg::LIMW] !== exp_r.cnt)
          flag_mismatch("count", trdc_pkg::SW'(exp_r.cnt),
                        trdc_pkg::SW'(m_axis_tdata[trdc_pkg::OUT_CNT_LO +: trdc_pkg::LIMW]));
        if (m_axis_tdata[trdc_pkg::OUT_NEXT_LO +: trdc_pkg::CW] !== exp_r.next)
          flag_mismatch("next_index", trdc_pkg::SW'(exp_r.next),
                        trdc_pkg::SW'(m_axis_tdata[trdc_pkg::OUT_NEXT_LO +: trdc_pkg::CW]));
        if (m_axis_tdata[trdc_pkg::OUT_DROP_LO +: trdc_pkg::CW] !== exp_r.lost)
          flag_mismatch("dropped", trdc_pkg::SW'(exp_r.lost),
                        trdc_pkg::SW'(m_axis_tdata[trdc_pkg::OUT_DROP_LO +: trdc_pkg::CW]));
        if (m_axis_tdata[trdc_pkg::OUT_TOT_LO +: trdc_pkg::CW] !== exp_r.total)
          flag_mismatch("total_pushed", trdc_pkg::SW'(exp_r.total),
                        trdc_pkg::SW'(m_axis_tdata[trdc_pkg::OUT_TOT_LO +: trdc_pkg::CW]));
      end
    end
  end

  // Watchdog: too long without any transaction
  always @(posedge clk) begin
    if (rst || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (cfg_valid && cfg_ready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("%0t: timeout, %0d results still outstanding", $time, pending_results.size());
      $display("Some tests failed");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  initial begin
    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_default_capacity();
    test_overwrite_drop();
    test_capacity_extremes();
    test_output_backpressure();
    test_random_traffic(20, 57, 87);
    test_random_traffic(57, 20, 87);
    test_random_traffic(0, 0, 87);
    wait_idle();

    if (pending_results.size() != 0) begin
      err_count++;
      $display("%0t: %0d expected results never arrived", $time, pending_results.size());
    end
    $display("Run covered %0d pushes, %0d drains, %0d snapshots, %0d ignored requests",
             n_push, n_drain, n_snap, n_ignored);
    $display("%0d capacity writes, %0d results checked (%0d carrying samples)",
             n_cap_writes, n_checked, n_samples);
    if (err_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
